// File: hw/rtl/sorted_page_range_coalescer_defines.svh
// ----------------------------------------------------------------------------
// Sorted page range coalescer assertion macros
// Shared property forms for the checker files of the coalescer.
// ----------------------------------------------------------------------------
`ifndef SORTED_PAGE_RANGE_COALESCER_DEFINES_SVH
`define SORTED_PAGE_RANGE_COALESCER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define SPRC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sprc assertion failed");

// Next-cycle implication, disabled while reset is held.
`define SPRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sprc assertion failed");

`endif

// File: hw/rtl/sprc_pkg.sv
// ----------------------------------------------------------------------------
// Sorted page range coalescer package
// Field widths, result kinds and the shared record types.
// ----------------------------------------------------------------------------
package sprc_pkg;

    localparam int GROUP_BITS = 32;
    localparam int PAGE_BITS  = 31;
    localparam int LEN_BITS   = PAGE_BITS + 1;
    localparam int END_BITS   = PAGE_BITS + 2;
    localparam int KIND_BITS  = 2;

    localparam int NUM_SLOTS = 5;
    localparam int SLOT_BITS = $clog2(NUM_SLOTS);
    localparam int CNT_BITS  = $clog2(NUM_SLOTS + 1);

    localparam int IN_DATA_BITS  = ((GROUP_BITS + 2 * PAGE_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = ((GROUP_BITS + PAGE_BITS + LEN_BITS + 7) / 8) * 8;

    localparam logic [KIND_BITS-1:0] KIND_RANGE      = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_GROUP_END  = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_STREAM_END = 2'd2;

    typedef struct packed {
        logic [KIND_BITS-1:0]  kind;
        logic [GROUP_BITS-1:0] group;
        logic [PAGE_BITS-1:0]  first;
        logic [LEN_BITS-1:0]   pages;
    } res_t;

    typedef struct packed {
        logic                  open;
        logic [GROUP_BITS-1:0] group;
        logic [PAGE_BITS-1:0]  first;
        logic [LEN_BITS-1:0]   length;
    } range_state_t;

    typedef struct packed {
        res_t [NUM_SLOTS-1:0] ent;
        logic [CNT_BITS-1:0]  cnt;
    } batch_t;

endpackage

// File: hw/rtl/sorted_page_range_coalescer.sv
// ----------------------------------------------------------------------------
// Sorted page range coalescer
// Merges sorted page-access records into one open range per group and
// emits ranges, group-end and stream-end words.
// ----------------------------------------------------------------------------
// Channel  Direction  Content
// s_*      in         one access record: group tag, start page, page count
// m_*      out        range, group-end or stream-end word
//
// A record is merged against the open range in the cycle it is accepted.
// Its words, zero to five, are held in the slot registers and leave one per cycle
// from the output register while m_tready is high.
// Records that release no word are taken every cycle; otherwise intake
// follows the output, one word per cycle, limited by the single output port.
// Reset is synchronous, closes the open range and holds s_tready low.
// A stall on m_tready holds the current word and stops intake while any word
// of the last record is still waiting.
module sorted_page_range_coalescer
    import sprc_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // group_tag, start_page, page_count, zero fill
    input  logic [IN_DATA_BITS-1:0]  s_tdata,
    input  logic                     s_tlast,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // out_group, range_first, range_pages, zero fill
    output logic [OUT_DATA_BITS-1:0] m_tdata,
    // kind
    output logic [KIND_BITS-1:0]     m_tuser,
    output logic                     m_tlast
);

    range_state_t         state_reg;
    range_state_t         state_next;
    batch_t               batch;
    res_t [NUM_SLOTS-1:0] ent_reg;
    logic [CNT_BITS-1:0]  cnt_reg;
    res_t                 out_reg;
    logic                 m_tvalid_reg;
    logic                 m_tlast_reg;
    logic                 out_free;
    logic                 emit;
    logic                 accept;

    sprc_merge u_merge (
        .group_tag  (s_tdata[GROUP_BITS-1:0]),
        .start_page (s_tdata[GROUP_BITS+PAGE_BITS-1:GROUP_BITS]),
        .page_count (s_tdata[GROUP_BITS+2*PAGE_BITS-1:GROUP_BITS+PAGE_BITS]),
        .stream_end (s_tlast),
        .cur_state  (state_reg),
        .next_state (state_next),
        .batch      (batch)
    );

    assign out_free = !m_tvalid_reg || m_tready;
    assign emit     = (cnt_reg != '0) && out_free;
    assign s_tready = aresetn &&
                      ((cnt_reg == '0) || ((cnt_reg == CNT_BITS'(1)) && out_free));
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= '0;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (accept) begin
                state_reg <= state_next;
                cnt_reg   <= batch.cnt;
            end else if (emit) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
            if (emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            ent_reg <= batch.ent;
        end else if (emit) begin
            for (int i = 0; i < NUM_SLOTS - 1; i++) begin
                ent_reg[i] <= ent_reg[i+1];
            end
        end
        if (emit) begin
            out_reg     <= ent_reg[0];
            m_tlast_reg <= (cnt_reg == CNT_BITS'(1));
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = OUT_DATA_BITS'({out_reg.pages, out_reg.first, out_reg.group});

endmodule

// File: hw/rtl/sprc_merge.sv
// ----------------------------------------------------------------------------
// Sorted page range coalescer merge logic
// Compares one record with the open range, forms the next range state and
// the ordered list of words that the record releases.
// ----------------------------------------------------------------------------
module sprc_merge
    import sprc_pkg::*;
(
    input  logic [GROUP_BITS-1:0] group_tag,
    input  logic [PAGE_BITS-1:0]  start_page,
    input  logic [PAGE_BITS-1:0]  page_count,
    input  logic                  stream_end,
    input  range_state_t          cur_state,
    output range_state_t          next_state,
    output batch_t                batch
);

    logic                 flush;
    logic                 cont;
    logic                 covered;
    logic                 touch;
    logic                 past;
    logic [END_BITS-1:0]  cur_end;
    logic [END_BITS-1:0]  new_end;
    logic [LEN_BITS-1:0]  merged;
    logic [PAGE_BITS-1:0] fin_first;
    logic [LEN_BITS-1:0]  fin_len;
    logic [SLOT_BITS-1:0] base;
    res_t                 r_old;
    res_t                 g_old;
    res_t                 r_fin;
    res_t                 g_fin;
    res_t                 s_fin;

    always_comb begin
        flush   = cur_state.open && (group_tag != cur_state.group);
        cont    = cur_state.open && !flush;
        cur_end = END_BITS'(cur_state.first) + END_BITS'(cur_state.length);
        new_end = END_BITS'(start_page) + END_BITS'(page_count);
        covered = cont && (cur_end >= new_end);
        touch   = cont && !covered && (cur_end >= END_BITS'(start_page));
        past    = cont && !covered && !touch;
        merged  = LEN_BITS'(new_end - END_BITS'(cur_state.first));

        fin_first = (cont && !past) ? cur_state.first : start_page;
        if (covered) begin
            fin_len = cur_state.length;
        end else if (touch) begin
            fin_len = merged;
        end else begin
            fin_len = LEN_BITS'(page_count);
        end

        r_old.kind  = KIND_RANGE;
        r_old.group = cur_state.group;
        r_old.first = cur_state.first;
        r_old.pages = cur_state.length;

        g_old.kind  = KIND_GROUP_END;
        g_old.group = cur_state.group;
        g_old.first = '0;
        g_old.pages = '0;

        r_fin.kind  = KIND_RANGE;
        r_fin.group = group_tag;
        r_fin.first = fin_first;
        r_fin.pages = fin_len;

        g_fin.kind  = KIND_GROUP_END;
        g_fin.group = group_tag;
        g_fin.first = '0;
        g_fin.pages = '0;

        s_fin.kind  = KIND_STREAM_END;
        s_fin.group = '0;
        s_fin.first = '0;
        s_fin.pages = '0;

        batch = '0;
        if (flush) begin
            batch.ent[0] = r_old;
            batch.ent[1] = g_old;
            base = SLOT_BITS'(2);
        end else if (past) begin
            batch.ent[0] = r_old;
            base = SLOT_BITS'(1);
        end else begin
            base = '0;
        end

        if (stream_end) begin
            batch.ent[base]                   = r_fin;
            batch.ent[SLOT_BITS'(base + 1'b1)] = g_fin;
            batch.ent[SLOT_BITS'(base + 2'd2)] = s_fin;
            batch.cnt = CNT_BITS'(base) + CNT_BITS'(3);
        end else begin
            batch.cnt = CNT_BITS'(base);
        end

        if (stream_end) begin
            next_state = '0;
        end else begin
            next_state.open   = 1'b1;
            next_state.group  = group_tag;
            next_state.first  = fin_first;
            next_state.length = fin_len;
        end
    end

endmodule

// File: hw/rtl/sprc_checker.sv
// ----------------------------------------------------------------------------
// Sorted page range coalescer checker
// Port-level properties of the coalescer, bound to the top level.
// ----------------------------------------------------------------------------
`include "sorted_page_range_coalescer_defines.svh"

module sprc_checker
    import sprc_pkg::*;
(
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_tvalid,
    input logic                     s_tready,
    input logic                     s_tlast,
    input logic                     m_tvalid,
    input logic                     m_tready,
    input logic [OUT_DATA_BITS-1:0] m_tdata,
    input logic [KIND_BITS-1:0]     m_tuser,
    input logic                     m_tlast
);

    logic s_word;
    logic s_final;

    assign s_word  = s_tvalid && s_tready;
    assign s_final = s_word && s_tlast;

    // A stalled word holds.
    `SPRC_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

    // The stream-end word always closes the run of its record.
    `SPRC_ASSERT_IMPLY(a_stream_end_last, aclk, aresetn,
        m_tvalid && (m_tuser == KIND_STREAM_END), m_tlast)

    // The stream-end word carries no group and no range.
    `SPRC_ASSERT_IMPLY(a_stream_end_zero, aclk, aresetn,
        m_tvalid && (m_tuser == KIND_STREAM_END), m_tdata == '0)

    // A final record always releases words, so intake stops right after it.
    `SPRC_ASSERT_NEXT(a_final_blocks, aclk, aresetn, s_final, !s_tready)

endmodule

bind sorted_page_range_coalescer sprc_checker u_sprc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// File: sim/sorted_page_range_coalescer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted page range coalescer testbench
// Streams sorted page-access records, including empty and unsorted ones, into
// the coalescer under random bursts and output stalls, predicts every range
// and marker word, and checks each word leaving the result port in order.
// ----------------------------------------------------------------------------
module sorted_page_range_coalescer_tb;
    import sprc_pkg::*;

    localparam int RANDOM_ITEMS = 330;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AFTER   = 100;

    localparam logic [PAGE_BITS-1:0]  PAGE_MAX  = {PAGE_BITS{1'b1}};
    localparam logic [GROUP_BITS-1:0] GROUP_MAX = {GROUP_BITS{1'b1}};

    typedef struct packed {
        logic [GROUP_BITS-1:0] group;
        logic [PAGE_BITS-1:0]  start;
        logic [PAGE_BITS-1:0]  count;
        logic                  stream_end;
    } access_t;

    typedef struct packed {
        logic [KIND_BITS-1:0]  kind;
        logic [GROUP_BITS-1:0] group;
        logic [PAGE_BITS-1:0]  first;
        logic [LEN_BITS-1:0]   pages;
        logic                  last;
    } out_word_t;

    typedef enum logic [1:0] {
        RDY_FULL,
        RDY_COIN,
        RDY_PERIODIC,
        RDY_SPARSE
    } ready_mode_e;

    logic                     aclk     = 1'b0;
    logic                     aresetn  = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [IN_DATA_BITS-1:0]  s_tdata  = '0;
    logic                     s_tlast  = 1'b0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_tdata;
    logic [KIND_BITS-1:0]     m_tuser;
    logic                     m_tlast;

    access_t   access_q[$];
    out_word_t expected_words[$];
    out_word_t run_words[$];

    int next_rec       = 0;
    int gap_left       = 0;
    int burst_left     = 0;
    int records_taken  = 0;
    int mismatch_cnt   = 0;

    logic                  range_is_open = 1'b0;
    logic [GROUP_BITS-1:0] range_group   = '0;
    logic [PAGE_BITS-1:0]  range_first   = '0;
    logic [LEN_BITS-1:0]   range_len     = '0;

    sorted_page_range_coalescer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic void add_access(input logic [GROUP_BITS-1:0] group,
                                       input logic [PAGE_BITS-1:0] start,
                                       input logic [PAGE_BITS-1:0] count,
                                       input logic stream_end);
        access_q.push_back(access_t'{group, start, count, stream_end});
    endfunction

    function automatic void emit_word(input logic [KIND_BITS-1:0] kind,
                                      input logic [GROUP_BITS-1:0] group,
                                      input logic [PAGE_BITS-1:0] first,
                                      input logic [LEN_BITS-1:0] pages);
        run_words.push_back(out_word_t'{kind, group, first, pages, 1'b0});
    endfunction

    function automatic void close_group();
        emit_word(KIND_RANGE, range_group, range_first, range_len);
        emit_word(KIND_GROUP_END, range_group, '0, '0);
    endfunction

    // Merges one record into the open range and queues the words it releases.
    function automatic void coalesce_record(input access_t a);
        logic [END_BITS-1:0] cur_end;
        logic [END_BITS-1:0] new_end;
        run_words.delete();
        if (range_is_open && a.group != range_group) begin
            close_group();
            range_is_open = 1'b0;
        end
        if (!range_is_open) begin
            range_is_open = 1'b1;
            range_group   = a.group;
            range_first   = a.start;
            range_len     = LEN_BITS'(a.count);
        end else begin
            cur_end = END_BITS'(range_first) + END_BITS'(range_len);
            new_end = END_BITS'(a.start) + END_BITS'(a.count);
            if (cur_end >= new_end) begin
            end else if (cur_end >= END_BITS'(a.start)) begin
                range_len = LEN_BITS'(new_end - END_BITS'(range_first));
            end else begin
                emit_word(KIND_RANGE, range_group, range_first, range_len);
                range_first = a.start;
                range_len   = LEN_BITS'(a.count);
            end
        end
        if (a.stream_end) begin
            close_group();
            emit_word(KIND_STREAM_END, '0, '0, '0);
            range_is_open = 1'b0;
            range_group   = '0;
            range_first   = '0;
            range_len     = '0;
        end
        if (run_words.size() > 0) begin
            run_words[run_words.size()-1].last = 1'b1;
        end
        foreach (run_words[i]) begin
            expected_words.push_back(run_words[i]);
        end
    endfunction

    initial begin : stimulus
        logic [GROUP_BITS-1:0] grp;
        logic [63:0]           edge_pg;
        logic [63:0]           st;
        logic [63:0]           cnt;
        int                    n_groups;
        int                    n_recs;
        int                    target;

        // Opening, dropping, touching, overlapping and leaving a range.
        add_access('0, '0, 31'd1, 1'b0);
        add_access('0, '0, 31'd1, 1'b0);
        add_access('0, 31'd1, 31'd2, 1'b0);
        add_access('0, 31'd2, 31'd5, 1'b0);
        add_access('0, 31'd10, 31'd3, 1'b0);
        // Empty accesses at the range end and past it.
        add_access('0, 31'd13, 31'd0, 1'b0);
        add_access('0, 31'd20, 31'd0, 1'b0);
        add_access('0, 31'd20, 31'd4, 1'b0);
        // Unsorted records: one reaching beyond the range, one lying before its start.
        add_access('0, 31'd5, 31'd30, 1'b0);
        add_access('0, 31'd3, 31'd1, 1'b0);
        // Field extremes, with a group change and the longest merged length.
        add_access(GROUP_MAX, PAGE_MAX, PAGE_MAX, 1'b0);
        add_access(GROUP_MAX, PAGE_MAX, PAGE_MAX, 1'b1);
        add_access(32'h5A5A5A5A, '0, PAGE_MAX, 1'b0);
        add_access(32'h5A5A5A5A, PAGE_MAX, PAGE_MAX, 1'b0);
        // Group change on the final record releases five words.
        add_access(32'hA5A5A5A5, 31'd100, 31'd1, 1'b1);
        add_access(32'h12345678, 31'd7, 31'd9, 1'b1);
        add_access(32'd1, '0, '0, 1'b1);
        add_access(32'd3, 31'd40, 31'd2, 1'b0);
        add_access(32'd3, 31'd50, 31'd1, 1'b1);

        target = access_q.size() + RANDOM_ITEMS;
        while (access_q.size() < target) begin
            if ($urandom_range(0, 9) == 0) begin
                grp = ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 3);
                cnt = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 40);
                add_access(grp, PAGE_BITS'($urandom), PAGE_BITS'(cnt),
                           $urandom_range(0, 7) == 0);
            end else begin
                n_groups = $urandom_range(1, 4);
                for (int g = 0; g < n_groups; g++) begin
                    grp = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom;
                    if ($urandom_range(0, 7) == 0) begin
                        edge_pg = 64'(PAGE_MAX) - $urandom_range(0, 300);
                    end else begin
                        edge_pg = $urandom_range(0, 5000);
                    end
                    n_recs = $urandom_range(1, 8);
                    for (int r = 0; r < n_recs; r++) begin
                        case ($urandom_range(0, 3))
                            0: begin
                                st = edge_pg;
                            end
                            1: begin
                                st = edge_pg + $urandom_range(1, 60);
                            end
                            default: begin
                                cnt = $urandom_range(0, 12);
                                st  = (edge_pg > cnt) ? edge_pg - cnt : 0;
                            end
                        endcase
                        if (st > 64'(PAGE_MAX)) begin
                            st = 64'(PAGE_MAX);
                        end
                        case ($urandom_range(0, 15))
                            0:       cnt = 0;
                            1:       cnt = $urandom & 64'(PAGE_MAX);
                            default: cnt = $urandom_range(1, 16);
                        endcase
                        if (st + cnt > edge_pg) begin
                            edge_pg = st + cnt;
                        end
                        add_access(grp, PAGE_BITS'(st), PAGE_BITS'(cnt),
                                   (g == n_groups - 1) && (r == n_recs - 1));
                    end
                end
            end
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        while (records_taken < access_q.size() || expected_words.size() != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatch_cnt == 0) begin
            $display("sorted_page_range_coalescer verification clean");
        end else begin
            $display("sorted_page_range_coalescer verification failed");
        end
        $finish;
    end

    always @(posedge aclk) begin : drive
        logic [IN_DATA_BITS-1:0] word_bits;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                next_rec++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (next_rec < access_q.size()) begin
                    word_bits = '0;
                    word_bits[GROUP_BITS-1:0] = access_q[next_rec].group;
                    word_bits[GROUP_BITS +: PAGE_BITS] = access_q[next_rec].start;
                    word_bits[GROUP_BITS+PAGE_BITS +: PAGE_BITS] = access_q[next_rec].count;
                    s_tvalid <= 1'b1;
                    s_tdata  <= word_bits;
                    s_tlast  <= access_q[next_rec].stream_end;
                    if (burst_left <= 1) begin
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                                 : $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : sink_ready
        ready_mode_e mode;
        int          mode_left;
        int          hold_left;
        int          words_taken;
        int          phase;
        bit          hold_done;
        if (!aresetn) begin
            m_tready    <= 1'b0;
            mode        = RDY_FULL;
            mode_left   = 0;
            hold_left   = 0;
            words_taken = 0;
            phase       = 0;
            hold_done   = 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                words_taken++;
            end
            phase++;
            if (!hold_done && words_taken >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = ready_mode_e'($urandom_range(0, 3));
                    mode_left = $urandom_range(10, 60);
                end
                mode_left--;
                case (mode)
                    RDY_FULL:     m_tready <= 1'b1;
                    RDY_COIN:     m_tready <= 1'($urandom_range(0, 1));
                    RDY_PERIODIC: m_tready <= (phase % 3) != 0;
                    default:      m_tready <= $urandom_range(0, 7) == 0;
                endcase
            end
        end
    end

    always @(posedge aclk) begin : observe
        out_word_t got;
        out_word_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                coalesce_record(access_t'{s_tdata[GROUP_BITS-1:0],
                                          s_tdata[GROUP_BITS +: PAGE_BITS],
                                          s_tdata[GROUP_BITS+PAGE_BITS +: PAGE_BITS],
                                          s_tlast});
                records_taken++;
            end
            if (m_tvalid && m_tready) begin
                got = out_word_t'{m_tuser, m_tdata[GROUP_BITS-1:0],
                                  m_tdata[GROUP_BITS +: PAGE_BITS],
                                  m_tdata[GROUP_BITS+PAGE_BITS +: LEN_BITS], m_tlast};
                if (expected_words.size() == 0) begin
                    mismatch_cnt++;
                    $display("%0t: unexpected word kind=%0d group=%h first=%h pages=%h last=%b",
                             $time, got.kind, got.group, got.first, got.pages, got.last);
                end else begin
                    want = expected_words.pop_front();
                    if (got.kind !== want.kind || got.group !== want.group ||
                        got.first !== want.first || got.pages !== want.pages ||
                        got.last !== want.last) begin
                        mismatch_cnt++;
                        $display("%0t: expected kind=%0d group=%h first=%h pages=%h last=%b",
                                 $time, want.kind, want.group, want.first, want.pages,
                                 want.last);
                        $display("%0t: actual   kind=%0d group=%h first=%h pages=%h last=%b",
                                 $time, got.kind, got.group, got.first, got.pages, got.last);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        int idle_cycles;
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("sorted_page_range_coalescer verification failed");
                $finish;
            end
        end
    end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/sprc_pkg.sv
hw/rtl/sprc_merge.sv
hw/rtl/sorted_page_range_coalescer.sv
hw/rtl/sprc_checker.sv
sim/sorted_page_range_coalescer_tb.sv
